[rtl/tbd_pkg.sv]
`default_nettype none

package tbd_pkg;

  localparam int BLOCK_LEN        = 16;
  localparam int MAX_UNIQUE       = 256;
  localparam int ELEMENT_BITS     = 10;
  localparam int TABLE_ELEMENTS   = 1114112;
  localparam int BLOCKS_PER_TABLE = TABLE_ELEMENTS / BLOCK_LEN;

  localparam int FILL_W = $clog2(BLOCK_LEN);
  localparam int ROW_W  = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;
  localparam int CNT_W  = 9;
  localparam int BLK_W  = 17;
  localparam int OFF_W  = 21;
  localparam int VAL_W  = 10;

  typedef logic [ELEMENT_BITS-1:0] tbd_elem_t;
  typedef tbd_elem_t [BLOCK_LEN-1:0] tbd_block_t;

  typedef struct packed {
    logic [VAL_W-1:0] element_value;
    logic             clear;
  } tbd_in_t;

  typedef struct packed {
    logic [OFF_W-1:0] block_offset;
    logic             is_new;
    logic [CNT_W-1:0] unique_count;
    logic             overflow;
  } tbd_out_t;

  // one stored unique block with the number of the block where it began
  typedef struct packed {
    logic [BLK_W-1:0] start_blk;
    tbd_block_t       blk;
  } tbd_row_t;

  // status from the collector to the sequencer
  typedef struct packed {
    logic             done;
    logic [BLK_W-1:0] blk_num;
  } tbd_fill_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } tbd_state_t;

  function automatic logic [OFF_W-1:0] tbd_offset(input logic [BLK_W-1:0] blk_num);
    tbd_offset = OFF_W'(OFF_W'(blk_num) * OFF_W'(BLOCK_LEN));
  endfunction

endpackage

`default_nettype wire

[rtl/table_block_deduplicator_unit.sv]
`default_nettype none

// Channel   Ports                      Handshake
// request   start, busy, in_req        taken when start is high and busy is low
// result    out_valid, out_rsp         one-cycle strobe, cannot be stalled
//
// A request that does not complete a block leaves busy low. A request that
// completes a block holds busy while the store is searched, one stored block
// per cycle through the single read port of the store, until a match or the
// last stored block. The result strobes in the same cycle that busy falls.
// Reset is synchronous, active low, and empties the store logically (count to
// zero); the store memory itself is not cleared. The receiver cannot stall, so
// results are never held.

module table_block_deduplicator_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire tbd_pkg::tbd_in_t  in_req,
  output logic                   out_valid,
  output tbd_pkg::tbd_out_t      out_rsp
);
  import tbd_pkg::*;

  tbd_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic             cmp_valid_r, cmp_valid_nxt;
  logic [BLK_W-1:0] blk_r, blk_nxt;
  logic             out_valid_r, out_valid_nxt;
  tbd_out_t         out_rsp_r, out_rsp_nxt;

  logic       acc;
  logic       issue;
  logic       hit;
  logic       wr_en;
  tbd_fill_t  fill;
  tbd_block_t cur_block;
  tbd_row_t   wr_row;
  tbd_row_t   rd_row;

  assign busy = (state_r != ST_IDLE);
  assign acc  = start && !busy;

  tbd_collect u_collect (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .req       (in_req),
    .fill      (fill),
    .cur_block (cur_block)
  );

  // issue one store read per cycle while entries remain unread
  assign issue = (state_r == ST_SEARCH) && (k_r < total_r);

  // shared row comparator: whole block against the row read last cycle
  assign hit = cmp_valid_r && (rd_row.blk == cur_block);

  assign wr_row.start_blk = blk_r;
  assign wr_row.blk       = cur_block;

  tbd_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (total_r[ROW_W-1:0]),
    .wr_row  (wr_row),
    .rd_en   (issue),
    .rd_addr (k_r[ROW_W-1:0]),
    .rd_row  (rd_row)
  );

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    k_nxt         = k_r;
    cmp_valid_nxt = 1'b0;
    blk_nxt       = blk_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    wr_en         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          // drop the store count on clear before the element is taken
          if (in_req.clear) begin
            total_nxt = '0;
          end
          if (fill.done) begin
            blk_nxt   = fill.blk_num;
            k_nxt     = '0;
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          // report the first occurrence
          out_valid_nxt            = 1'b1;
          out_rsp_nxt.block_offset = tbd_offset(rd_row.start_blk);
          out_rsp_nxt.is_new       = 1'b0;
          out_rsp_nxt.unique_count = total_r;
          out_rsp_nxt.overflow     = 1'b0;
          state_nxt                = ST_IDLE;
        end else if (!issue) begin
          // every stored block missed: append, or flag a full store
          out_valid_nxt            = 1'b1;
          out_rsp_nxt.block_offset = tbd_offset(blk_r);
          if (total_r < CNT_W'(MAX_UNIQUE)) begin
            wr_en                    = 1'b1;
            total_nxt                = total_r + CNT_W'(1);
            out_rsp_nxt.is_new       = 1'b1;
            out_rsp_nxt.unique_count = total_r + CNT_W'(1);
            out_rsp_nxt.overflow     = 1'b0;
          end else begin
            out_rsp_nxt.is_new       = 1'b0;
            out_rsp_nxt.unique_count = total_r;
            out_rsp_nxt.overflow     = 1'b1;
          end
          state_nxt = ST_IDLE;
        end else begin
          // advance to the next stored block
          k_nxt         = k_r + CNT_W'(1);
          cmp_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      k_r         <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      k_r         <= k_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r     <= blk_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

`ifndef SYNTHESIS
  // a result only ever follows a search
  a_result_after_search: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_SEARCH))
    else $error("result strobe without a preceding search");

  // the store count never passes the store size
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(MAX_UNIQUE))
    else $error("unique count beyond store size");

  // overflow only with a full store and never together with a new block
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rsp_r.overflow |->
      !out_rsp_r.is_new && (out_rsp_r.unique_count == CNT_W'(MAX_UNIQUE)))
    else $error("overflow reported with store not full");

  // an appended block raises the count by one
  a_new_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rsp_r.is_new |-> total_r == out_rsp_r.unique_count)
    else $error("new block without matching count");
`endif

endmodule

`default_nettype wire

[rtl/tbd_collect.sv]
`default_nettype none

module tbd_collect (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc,
  input  wire tbd_pkg::tbd_in_t  req,
  output tbd_pkg::tbd_fill_t     fill,
  output tbd_pkg::tbd_block_t    cur_block
);
  import tbd_pkg::*;

  tbd_block_t       block_r;
  logic [FILL_W-1:0] fill_r, fill_nxt, pos;
  logic [BLK_W-1:0]  blknum_r, blknum_nxt, blk_cur;
  logic [BLK_W:0]    blk_inc;

  always_comb begin
    pos        = req.clear ? '0 : fill_r;
    blk_cur    = req.clear ? '0 : blknum_r;
    blk_inc    = {1'b0, blk_cur} + (BLK_W+1)'(1);
    fill.done  = acc && (pos == FILL_W'(BLOCK_LEN - 1));
    fill.blk_num = blk_cur;
    fill_nxt   = fill_r;
    blknum_nxt = blknum_r;
    if (acc) begin
      if (fill.done) begin
        fill_nxt = '0;
        // wrap at the end of the table
        if (blk_inc >= (BLK_W+1)'(BLOCKS_PER_TABLE)) begin
          blknum_nxt = '0;
        end else begin
          blknum_nxt = blk_inc[BLK_W-1:0];
        end
      end else begin
        fill_nxt   = pos + FILL_W'(1);
        blknum_nxt = blk_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      blknum_r <= '0;
    end else begin
      fill_r   <= fill_nxt;
      blknum_r <= blknum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_r <= '0;
    end else if (acc) begin
      block_r[pos] <= req.element_value[ELEMENT_BITS-1:0];
    end
  end

  assign cur_block = block_r;

endmodule

`default_nettype wire

[rtl/tbd_store.sv]
`default_nettype none

module tbd_store (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [tbd_pkg::ROW_W-1:0] wr_addr,
  input  wire tbd_pkg::tbd_row_t         wr_row,
  input  wire logic                      rd_en,
  input  wire logic [tbd_pkg::ROW_W-1:0] rd_addr,
  output tbd_pkg::tbd_row_t              rd_row
);
  import tbd_pkg::*;

  tbd_row_t mem [MAX_UNIQUE];
  tbd_row_t rd_row_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r <= mem[rd_addr];
    end
  end

  assign rd_row = rd_row_r;

endmodule

`default_nettype wire

[tb/table_block_deduplicator_unit_tb.sv]
module table_block_deduplicator_unit_tb;
  import tbd_pkg::*;

  // No request may go unaccepted and no result may go missing for this long.
  // The slowest request searches a full store; even with the longest sender gap
  // this leaves a wide margin.
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = MAX_UNIQUE + 8;
  localparam int TOTAL_ITEMS   = 1750;
  localparam int HISTORY_DEPTH = 64;

  // Expected result of the first block after a clear: new, offset 0, one stored.
  localparam tbd_out_t FIRST_BLOCK_NEW = {OFF_W'(0), 1'b1, CNT_W'(1), 1'b0};
  localparam tbd_out_t NO_RESULT       = '0;

  typedef struct packed {
    tbd_in_t  req;
    logic     typed;
    tbd_out_t want;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  tbd_in_t  in_req;
  logic     out_valid;
  tbd_out_t out_rsp;

  // Dedup predictor state: block being filled, store of unique blocks
  tbd_block_t       fill_blk;
  int unsigned      fill_pos;
  int unsigned      blk_num;
  int unsigned      stored_cnt;
  tbd_block_t       stored_rows [MAX_UNIQUE];
  logic [BLK_W-1:0] stored_first [MAX_UNIQUE];

  tbd_out_t   pending_results [$];
  tbd_block_t sent_blocks [$];
  dir_row_t   dir_rows [$];
  int         mismatch_count = 0;
  int         stall_cycles = 0;
  int         requests_sent = 0;

  table_block_deduplicator_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Compare every field of a result on its own so each bad field gets its own line.
  task automatic check_result(input tbd_out_t got, input tbd_out_t want, input string src);
    if (got.block_offset !== want.block_offset)
      report_mismatch($sformatf("%s block_offset %0d, want %0d", src, got.block_offset,
                                want.block_offset));
    if (got.is_new !== want.is_new)
      report_mismatch($sformatf("%s is_new %b, want %b", src, got.is_new, want.is_new));
    if (got.unique_count !== want.unique_count)
      report_mismatch($sformatf("%s unique_count %0d, want %0d", src, got.unique_count,
                                want.unique_count));
    if (got.overflow !== want.overflow)
      report_mismatch($sformatf("%s overflow %b, want %b", src, got.overflow, want.overflow));
  endtask

  task automatic clear_dedup_state();
    fill_blk   = '0;
    fill_pos   = 0;
    blk_num    = 0;
    stored_cnt = 0;
  endtask

  // Take one element into the predicted block; when the block completes, search
  // the store and queue the result the block must produce.
  task automatic absorb_element(input tbd_in_t req);
    tbd_out_t    res;
    int unsigned this_blk;
    int          hit;
    if (req.clear) begin
      // drop the partial block and logically empty the store; contents stay
      fill_pos   = 0;
      blk_num    = 0;
      stored_cnt = 0;
    end
    fill_blk[fill_pos] = req.element_value[ELEMENT_BITS-1:0];
    fill_pos++;
    if (fill_pos < BLOCK_LEN) return;

    fill_pos = 0;
    this_blk = blk_num;
    // wrap the block number at the end of the table, keep the store
    blk_num  = (blk_num + 1 >= BLOCKS_PER_TABLE) ? 0 : blk_num + 1;

    // only entries below the stored count are ever looked at
    hit = -1;
    for (int k = 0; k < stored_cnt; k++) begin
      if (hit < 0 && stored_rows[k] == fill_blk) hit = k;
    end

    res = '0;
    if (hit >= 0) begin
      res.block_offset = OFF_W'(stored_first[hit] * BLOCK_LEN);
      res.unique_count = CNT_W'(stored_cnt);
    end else if (stored_cnt < MAX_UNIQUE) begin
      stored_rows[stored_cnt]  = fill_blk;
      stored_first[stored_cnt] = BLK_W'(this_blk);
      stored_cnt++;
      res.block_offset = OFF_W'(this_blk * BLOCK_LEN);
      res.is_new       = 1'b1;
      res.unique_count = CNT_W'(stored_cnt);
    end else begin
      // store full: report own offset and flag overflow, store nothing
      res.block_offset = OFF_W'(this_blk * BLOCK_LEN);
      res.unique_count = CNT_W'(stored_cnt);
      res.overflow     = 1'b1;
    end
    pending_results.push_back(res);
  endtask

  // Predict on each accepted request and check each result strobe.
  // Both sample pre-edge values, so order within the time step does not matter.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_dedup_state();
    end else begin
      if (start && !busy) absorb_element(in_req);
      if (out_valid) begin
        if (pending_results.size() == 0)
          report_mismatch($sformatf("result offset %0d with nothing expected",
                                    out_rsp.block_offset));
        else
          check_result(out_rsp, pending_results.pop_front(), "result");
      end
    end
  end

  // Watchdog: end the run if neither a request nor a result moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Drive one request and hold it until the block takes it.
  task automatic push_request(input tbd_in_t req);
    in_req <= req;
    start  <= 1'b1;
    do @(posedge clk); while (busy);
    requests_sent++;
  endtask

  // Drop start for a gap; a zero gap leaves start alone so the next request follows.
  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Bias toward the all-zeros and all-ones values.
  function automatic tbd_elem_t pick_element();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return tbd_elem_t'($urandom_range(0, (1 << ELEMENT_BITS) - 1));
  endfunction

  function automatic tbd_block_t fresh_block();
    tbd_block_t blk;
    for (int i = 0; i < BLOCK_LEN; i++) blk[i] = pick_element();
    return blk;
  endfunction

  function automatic tbd_block_t recall_block();
    return sent_blocks[$urandom_range(0, sent_blocks.size() - 1)];
  endfunction

  // Send a whole block as BLOCK_LEN requests, optionally clearing on the first one.
  task automatic send_block(input tbd_block_t blk, input bit clear_first, input bit paced);
    tbd_in_t req;
    sent_blocks.push_back(blk);
    if (sent_blocks.size() > HISTORY_DEPTH) void'(sent_blocks.pop_front());
    for (int i = 0; i < BLOCK_LEN; i++) begin
      req.element_value = blk[i];
      req.clear         = clear_first && (i == 0);
      push_request(req);
      if (paced) hold_off(pick_gap());
    end
  endtask

  // Leave a partial block behind; the caller follows with a clearing block.
  task automatic send_fragment();
    tbd_in_t req;
    int      n;
    n = $urandom_range(1, BLOCK_LEN - 1);
    for (int i = 0; i < n; i++) begin
      req.element_value = pick_element();
      req.clear         = 1'b0;
      push_request(req);
      hold_off(pick_gap());
    end
  endtask

  task automatic add_row(input logic [VAL_W-1:0] value, input bit clr, input bit typed,
                         input tbd_out_t want);
    dir_row_t row;
    row.req.element_value = value;
    row.req.clear         = clr;
    row.typed             = typed;
    row.want              = want;
    dir_rows.push_back(row);
  endtask

  initial begin
    tbd_block_t blk;
    int         r;
    bit         clr;
    bit         paced;

    rst_n  = 1'b0;
    start  = 1'b0;
    in_req = '0;

    // First block: extremes and alternating bit patterns, clear on its first request.
    add_row(10'h3FF, 1'b1, 1'b0, NO_RESULT);
    add_row(10'h000, 1'b0, 1'b0, NO_RESULT);
    add_row(10'h2AA, 1'b0, 1'b0, NO_RESULT);
    add_row(10'h155, 1'b0, 1'b0, NO_RESULT);
    add_row(10'h001, 1'b0, 1'b0, NO_RESULT);
    add_row(10'h200, 1'b0, 1'b0, NO_RESULT);
    add_row(10'h3FF, 1'b0, 1'b0, NO_RESULT);
    add_row(10'h000, 1'b0, 1'b0, NO_RESULT);
    add_row(10'h0F0, 1'b0, 1'b0, NO_RESULT);
    add_row(10'h30F, 1'b0, 1'b0, NO_RESULT);
    add_row(10'h155, 1'b0, 1'b0, NO_RESULT);
    add_row(10'h2AA, 1'b0, 1'b0, NO_RESULT);
    add_row(10'h3FE, 1'b0, 1'b0, NO_RESULT);
    add_row(10'h002, 1'b0, 1'b0, NO_RESULT);
    add_row(10'h100, 1'b0, 1'b0, NO_RESULT);
    // completing request: empty store, so new at offset 0 with count 1
    add_row(10'h3FF, 1'b0, 1'b1, FIRST_BLOCK_NEW);
    // partial block, then a clear arriving with five elements of the block filled
    add_row(10'h000, 1'b0, 1'b0, NO_RESULT);
    add_row(10'h3FF, 1'b0, 1'b0, NO_RESULT);
    add_row(10'h2AA, 1'b0, 1'b0, NO_RESULT);
    add_row(10'h155, 1'b0, 1'b0, NO_RESULT);
    add_row(10'h07F, 1'b0, 1'b0, NO_RESULT);
    add_row(10'h3FF, 1'b1, 1'b0, NO_RESULT);
    add_row(10'h000, 1'b0, 1'b0, NO_RESULT);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed rows; where a result is typed in, stop and wait for it.
    foreach (dir_rows[i]) begin
      push_request(dir_rows[i].req);
      if (dir_rows[i].typed) begin
        start <= 1'b0;
        do @(posedge clk); while (!out_valid);
        check_result(out_rsp, dir_rows[i].want, "directed");
      end
    end

    // Random blocks: repeats of recent blocks, near misses, fresh ones, and now
    // and then a clear, sometimes right after a stray partial block.
    send_block(fresh_block(), 1'b1, 1'b1);
    while (requests_sent < TOTAL_ITEMS) begin
      r     = $urandom_range(0, 99);
      paced = ($urandom_range(0, 3) != 0);
      clr   = 1'b0;
      if ($urandom_range(0, 24) == 0) begin
        clr = 1'b1;
        if ($urandom_range(0, 1) != 0) send_fragment();
      end
      if (r < 45) begin
        blk = recall_block();
      end else if (r < 60) begin
        blk = recall_block();
        blk[$urandom_range(0, BLOCK_LEN - 1)] = pick_element();
      end else begin
        blk = fresh_block();
      end
      send_block(blk, clr, paced);
    end

    // Drain: wait for every predicted result, then give the block time to show
    // anything extra.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
rtl/tbd_pkg.sv
rtl/tbd_collect.sv
rtl/tbd_store.sv
rtl/table_block_deduplicator_unit.sv
tb/table_block_deduplicator_unit_tb.sv
